FILE: hdl/ppmd_pkg.sv
// Package for the pulse pattern mode detector.
// Holds payload structs, mode codes and register indexes; no dependencies.
`timescale 1ns / 1ps

package ppmd_pkg;

  // Converter sample width and the width of the threshold registers.
  localparam int unsigned SampleBits = 10;
  localparam int unsigned ThreshBits = 10;
  localparam int unsigned MsBits     = 16;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned CountBits  = 3;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDatBits = 16;

  // Compare width covering both the sample and the thresholds.
  localparam int unsigned CmpBits = (SampleBits > ThreshBits) ? SampleBits : ThreshBits;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxBits-1:0] RegThreshHigh = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegThreshLow  = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegDebounce   = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegWindow     = 2'd3;

  // Register reset values.
  localparam logic [ThreshBits-1:0] ThreshHighRst = 10'd600;
  localparam logic [ThreshBits-1:0] ThreshLowRst  = 10'd400;
  localparam logic [MsBits-1:0]     DebounceRst   = 16'd50;
  localparam logic [MsBits-1:0]     WindowRst     = 16'd1000;

  localparam logic [CountBits-1:0]  CountMax      = 3'd7;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeTx   = 2'd1,
    ModeLock = 2'd2
  } mode_e;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic [TimeBits-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    mode_e                mode;
    logic                 pulse_accepted;
    logic                 window_closed;
    logic [CountBits-1:0] count_seen;
  } out_item_t;

  // Mode chosen by the final pulse count of a window.
  function automatic mode_e decide_mode(input logic [CountBits-1:0] count);
    mode_e m;
    case (count)
      3'd1:    m = ModeTx;
      3'd3:    m = ModeLock;
      default: m = ModeIdle;
    endcase
    return m;
  endfunction

endpackage

FILE: hdl/pulse_pattern_mode_detector.sv
// Top level of the pulse pattern mode detector: input register, per-sample
// decision logic and result register. Depends on ppmd_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | sink      | in_valid_i/in_stall_o | in_data_i  (in_item_t)
//  out     | source    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per cycle is sustained while the result port does not stall; each
// result passes through the input register, then the result register, before it
// appears on the result port.
// The rate rests on the state update: compares and two 32-bit timestamp
// subtractions that lie between the input register and the result register.
// Reset clears the control state and loads the register defaults.
// A stalled result holds the result register; the input register still takes
// one more request, and in_stall_o rises only when both registers are full.
`timescale 1ns / 1ps

module pulse_pattern_mode_detector
  import ppmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgDatBits-1:0] cfg_data_i
);

  // Configuration registers.
  logic [ThreshBits-1:0] th_high_q, th_low_q;
  logic [MsBits-1:0]     debounce_q, window_q;

  // Detector state.
  mode_e                mode_q, mode_d;
  logic                 level_q, level_d;
  logic [TimeBits-1:0]  last_pulse_q, last_pulse_d;
  logic [TimeBits-1:0]  win_start_q, win_start_d;
  logic                 win_open_q, win_open_d;
  logic [CountBits-1:0] count_q, count_d;

  // Pipeline registers.
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;

  logic advance, proc;
  logic pressed, released, ambiguous, pulse, close;
  logic [CmpBits-1:0]  sample_x, th_high_x, th_low_x;
  logic [TimeBits-1:0] since_pulse, since_start;
  logic [CountBits-1:0] count_up;
  mode_e shown;

  // The result register can take a new result when empty or being drained.
  assign advance     = !out_valid_q || !out_stall_i;
  assign proc        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_high_q  <= ThreshHighRst;
      th_low_q   <= ThreshLowRst;
      debounce_q <= DebounceRst;
      window_q   <= WindowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegThreshHigh: th_high_q  <= cfg_data_i[ThreshBits-1:0];
        RegThreshLow:  th_low_q   <= cfg_data_i[ThreshBits-1:0];
        RegDebounce:   debounce_q <= cfg_data_i[MsBits-1:0];
        RegWindow:     window_q   <= cfg_data_i[MsBits-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Level classification of the registered sample.
  always_comb begin
    sample_x  = CmpBits'(in_q.sample);
    th_high_x = CmpBits'(th_high_q);
    th_low_x  = CmpBits'(th_low_q);
    pressed   = sample_x > th_high_x;
    released  = sample_x < th_low_x;
    ambiguous = !pressed && !released;
  end

  // Pulse detection, window tracking and mode decision.
  always_comb begin
    since_pulse = in_q.now_ms - last_pulse_q;
    pulse = pressed && !level_q && (since_pulse > TimeBits'(debounce_q));
    count_up = (count_q == CountMax) ? count_q : count_q + 3'd1;

    level_d      = pressed;
    last_pulse_d = pulse ? in_q.now_ms : last_pulse_q;
    win_open_d   = win_open_q || pulse;
    win_start_d  = (pulse && !win_open_q) ? in_q.now_ms : win_start_q;
    if (pulse) begin
      count_d = win_open_q ? count_up : 3'd1;
    end else begin
      count_d = count_q;
    end

    // A window opened by this sample has zero age, so only an open one can close.
    since_start = in_q.now_ms - win_start_q;
    close = win_open_q && (since_start > TimeBits'(window_q));

    shown = close ? decide_mode(count_d) : mode_q;

    res.mode           = shown;
    res.pulse_accepted = pulse;
    res.window_closed  = close;
    res.count_seen     = count_d;

    mode_d = (shown == ModeLock) ? ModeIdle : shown;
    if (close) begin
      count_d    = '0;
      win_open_d = 1'b0;
    end

    // A sample between the thresholds leaves every piece of state alone.
    if (ambiguous) begin
      res.mode           = mode_q;
      res.pulse_accepted = 1'b0;
      res.window_closed  = 1'b0;
      res.count_seen     = count_q;
      mode_d       = mode_q;
      level_d      = level_q;
      last_pulse_d = last_pulse_q;
      win_start_d  = win_start_q;
      win_open_d   = win_open_q;
      count_d      = count_q;
    end
  end

  // State update, one sample per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeIdle;
      level_q      <= 1'b0;
      last_pulse_q <= '0;
      win_start_q  <= '0;
      win_open_q   <= 1'b0;
      count_q      <= '0;
    end else if (proc) begin
      mode_q       <= mode_d;
      level_q      <= level_d;
      last_pulse_q <= last_pulse_d;
      win_start_q  <= win_start_d;
      win_open_q   <= win_open_d;
      count_q      <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= res;
    end
  end

  // A closing sample always leaves the window shut.
  a_close_shuts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res.window_closed |=> !win_open_q)
    else $error("window still open after close");

  // An accepted pulse records its timestamp.
  a_pulse_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res.pulse_accepted |=> last_pulse_q == $past(in_q.now_ms))
    else $error("pulse timestamp not recorded");

  // A window only opens on a pulse, so it never closes with a zero count.
  a_close_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.window_closed |-> out_q.count_seen != 3'd0)
    else $error("window closed with zero count");

  // Locked is only reported, never held.
  a_no_lock_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> mode_q != ModeLock)
    else $error("locked mode held in state");

  // Input stalls only when both pipeline registers are occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/sv/ppmd_tb_pkg.sv
// Result checker for the pulse pattern mode detector testbench.
// Predicts each result from the accepted samples and compares it; uses ppmd_pkg.
`timescale 1ns / 1ps

package ppmd_tb_pkg;
  import ppmd_pkg::*;

  class ppmd_result_checker;
    // Register copies.
    logic [ThreshBits-1:0] thr_high;
    logic [ThreshBits-1:0] thr_low;
    logic [MsBits-1:0]     debounce;
    logic [MsBits-1:0]     window;

    // Detector state.
    mode_e                 held_mode;
    logic                  is_pressed;
    logic [TimeBits-1:0]   last_pulse;
    logic [TimeBits-1:0]   win_start;
    logic                  win_open;
    logic [CountBits-1:0]  count;

    out_item_t             mode_results_q[$];
    int                    errors;

    function new();
      thr_high   = ThreshHighRst;
      thr_low    = ThreshLowRst;
      debounce   = DebounceRst;
      window     = WindowRst;
      held_mode  = ModeIdle;
      is_pressed = 1'b0;
      last_pulse = '0;
      win_start  = '0;
      win_open   = 1'b0;
      count      = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDatBits-1:0] data);
      case (idx)
        RegThreshHigh: thr_high = data[ThreshBits-1:0];
        RegThreshLow:  thr_low  = data[ThreshBits-1:0];
        RegDebounce:   debounce = data[MsBits-1:0];
        RegWindow:     window   = data[MsBits-1:0];
        default: ;
      endcase
    endfunction

    // Advances the detector by one sample and returns the result it gives.
    function out_item_t predict_mode(in_item_t req);
      out_item_t           res;
      logic                pressed;
      logic [TimeBits-1:0] since_pulse;
      logic [TimeBits-1:0] since_open;
      res.mode           = held_mode;
      res.pulse_accepted = 1'b0;
      res.window_closed  = 1'b0;
      res.count_seen     = count;

      // The pressed test comes first, so a sample past both crossed thresholds reads as pressed.
      if (req.sample > thr_high) begin
        pressed = 1'b1;
      end else if (req.sample < thr_low) begin
        pressed = 1'b0;
      end else begin
        return res;
      end

      // A rising edge past the debounce time is a pulse; the first one opens a window.
      since_pulse = req.now_ms - last_pulse;
      if (pressed && !is_pressed && since_pulse > debounce) begin
        last_pulse         = req.now_ms;
        res.pulse_accepted = 1'b1;
        if (!win_open) begin
          win_open  = 1'b1;
          win_start = req.now_ms;
          count     = '0;
        end
        if (count < CountMax) count++;
      end
      is_pressed     = pressed;
      res.count_seen = count;

      // Window expiry decides the mode from the final count.
      since_open = req.now_ms - win_start;
      if (win_open && since_open > window) begin
        case (count)
          3'd1:    held_mode = ModeTx;
          3'd3:    held_mode = ModeLock;
          default: held_mode = ModeIdle;
        endcase
        res.window_closed = 1'b1;
        count             = '0;
        win_open          = 1'b0;
      end

      // Locked shows up in one result only.
      res.mode = held_mode;
      if (held_mode == ModeLock) held_mode = ModeIdle;
      return res;
    endfunction

    function void note_sample(in_item_t req);
      mode_results_q.push_back(predict_mode(req));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (mode_results_q.size() == 0) begin
        $error("unexpected result: mode %0d pulse %0d closed %0d count %0d",
               got.mode, got.pulse_accepted, got.window_closed, got.count_seen);
        errors++;
        return;
      end
      want = mode_results_q.pop_front();
      if (got.mode !== want.mode) begin
        $error("mode: expected %0d, actual %0d", want.mode, got.mode);
        errors++;
      end
      if (got.pulse_accepted !== want.pulse_accepted) begin
        $error("pulse_accepted: expected %0d, actual %0d",
               want.pulse_accepted, got.pulse_accepted);
        errors++;
      end
      if (got.window_closed !== want.window_closed) begin
        $error("window_closed: expected %0d, actual %0d",
               want.window_closed, got.window_closed);
        errors++;
      end
      if (got.count_seen !== want.count_seen) begin
        $error("count_seen: expected %0d, actual %0d", want.count_seen, got.count_seen);
        errors++;
      end
    endfunction

    function int pending();
      return mode_results_q.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/testbench.sv
// Top-level testbench of the pulse pattern mode detector: clock, reset, drivers and monitor.
// Depends on ppmd_pkg, ppmd_tb_pkg and the detector RTL.
`timescale 1ns / 1ps

module testbench;
  import ppmd_pkg::*;
  import ppmd_tb_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data     = '0;
  logic                  out_valid_o;
  logic                  out_stall   = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index   = '0;
  logic [CfgDatBits-1:0] cfg_data    = '0;

  ppmd_result_checker    sb = new();

  // Testbench view of the registers, used to pick samples of each class.
  logic [ThreshBits-1:0] cur_hi       = ThreshHighRst;
  logic [ThreshBits-1:0] cur_lo       = ThreshLowRst;
  logic [MsBits-1:0]     debounce_cfg = DebounceRst;
  logic [MsBits-1:0]     window_cfg   = WindowRst;

  logic [TimeBits-1:0]   clock_ms      = '0;
  logic [TimeBits-1:0]   last_press_ms = '0;
  int                    n_items       = 0;
  bit                    quiet         = 1'b0;
  int                    hold_cycles   = 0;
  int unsigned           cycle_count   = 0;

  pulse_pattern_mode_detector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.note_sample(in_data);
      if (out_valid_o && !out_stall) sb.check_result(out_data_o);
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = (hold_cycles > 0) ? hold_cycles : (quiet ? 0 : $urandom_range(0, 3));
      hold_cycles = 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [SampleBits-1:0] press_val();
    return SampleBits'($urandom_range(cur_hi + 1, 1023));
  endfunction

  function automatic logic [SampleBits-1:0] release_val();
    int top;
    top = (cur_hi < cur_lo) ? cur_hi : cur_lo - 1;
    return SampleBits'($urandom_range(0, top));
  endfunction

  // Offers one request after a random gap and returns once it is taken.
  task automatic send_sample(input logic [SampleBits-1:0] s, input logic [TimeBits-1:0] t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{sample: s, now_ms: t};
    do @(posedge clk_i); while (in_stall_o);
    if (!(s <= cur_hi && s >= cur_lo)) n_items++;
  endtask

  // Stops sending and waits until every predicted result has been checked.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Writes all four registers back to back; threshold writes carry junk upper bits.
  task automatic program_regs(input logic [ThreshBits-1:0] hi, input logic [ThreshBits-1:0] lo,
                              input logic [MsBits-1:0] deb, input logic [MsBits-1:0] win);
    logic [CfgIdxBits-1:0] idx;
    logic [CfgDatBits-1:0] val;
    logic [5:0]            junk;
    for (int i = 0; i < 4; i++) begin
      junk = 6'($urandom);
      case (i)
        0:       begin idx = RegThreshHigh; val = {junk, hi}; end
        1:       begin idx = RegThreshLow;  val = {junk, lo}; end
        2:       begin idx = RegDebounce;   val = deb;        end
        default: begin idx = RegWindow;     val = win;        end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx, val);
    end
    cfg_valid    <= 1'b0;
    cur_hi       = hi;
    cur_lo       = lo;
    debounce_cfg = deb;
    window_cfg   = win;
  endtask

  // One press pattern: some pulses with bounces and noise, then a sample past the window.
  task automatic run_pattern();
    int k;
    int r;
    int spread;
    r = $urandom_range(0, 9);
    k = (r < 3) ? 1 : (r < 6) ? 3 : $urandom_range(0, 9);

    // Occasionally start from arbitrary samples at arbitrary times.
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        clock_ms = $urandom;
        send_sample(SampleBits'($urandom), clock_ms);
      end
    end

    spread = window_cfg / (2 * (k + 1));
    for (int i = 0; i < k; i++) begin
      clock_ms += $urandom_range(1, 5);
      send_sample(release_val(), clock_ms);
      if ($urandom_range(0, 3) == 0 && cur_lo <= cur_hi) begin
        send_sample(SampleBits'($urandom_range(cur_lo, cur_hi)), $urandom);
      end
      // A quick press and release inside the debounce time.
      if ($urandom_range(0, 4) == 0) begin
        clock_ms += 1;
        send_sample(press_val(), clock_ms);
        clock_ms += 1;
        send_sample(release_val(), clock_ms);
      end
      clock_ms += debounce_cfg + 1 + $urandom_range(0, spread);
      // Now and then land right on the debounce limit.
      if ($urandom_range(0, 5) == 0) clock_ms = last_press_ms + debounce_cfg + $urandom_range(0, 1);
      send_sample(press_val(), clock_ms);
      last_press_ms = clock_ms;
    end

    clock_ms += window_cfg + 1 + $urandom_range(0, 20);
    if ($urandom_range(0, 9) == 0) clock_ms += $urandom;
    send_sample($urandom_range(0, 1) ? press_val() : release_val(), clock_ms);
  endtask

  initial begin
    logic [ThreshBits-1:0] hi;
    logic [ThreshBits-1:0] lo;
    logic [MsBits-1:0]     deb;
    logic [MsBits-1:0]     win;
    int                    target;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: boundaries, bounce, lock, transmit, pulse and close together.
    send_sample(10'd500,  32'd0);     // ambiguous right after reset
    send_sample(10'd1023, 32'd10);    // press within debounce of time zero
    send_sample(10'd0,    32'd20);
    send_sample(10'd601,  32'd100);   // first pulse opens the window
    send_sample(10'd399,  32'd110);
    send_sample(10'd700,  32'd130);   // bounce, rejected
    send_sample(10'd300,  32'd140);
    send_sample(10'd800,  32'd151);
    send_sample(10'd100,  32'd160);
    send_sample(10'd900,  32'd220);   // third pulse
    send_sample(10'd400,  32'd600);   // low threshold itself is ambiguous
    send_sample(10'd600,  32'd1100);  // high threshold itself is ambiguous, no close
    send_sample(10'd0,    32'd1101);  // close with three pulses: locked once
    send_sample(10'd500,  32'd1102);  // back to idle
    send_sample(10'd1023, 32'd2000);
    send_sample(10'd0,    32'd3000);  // exactly the window length, still open
    send_sample(10'd0,    32'd3001);  // close with one pulse: transmit
    send_sample(10'd500,  32'd3002);  // held mode shown on an ambiguous sample
    send_sample(10'd1023, 32'd4000);
    send_sample(10'd0,    32'd4010);
    send_sample(10'd1023, 32'd5001);  // pulse and close on one sample
    wait_idle();

    // Thresholds at their extremes: every sample is ambiguous.
    program_regs(10'd1023, 10'd0, 16'hFFFF, 16'hFFFF);
    send_sample(10'd1023, $urandom);
    send_sample(10'd0,    $urandom);
    wait_idle();

    // Crossed thresholds, zero debounce and window, timestamps wrapping.
    program_regs(10'd0, 10'd1023, 16'd0, 16'd0);
    send_sample(10'd0, 32'hFFFF_FFFE);
    send_sample(10'd1, 32'hFFFF_FFFF);
    send_sample(10'd0, 32'h0000_0002);
    wait_idle();
    clock_ms = 32'h0000_0002;

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      lo  = ThreshBits'($urandom_range(1, 700));
      hi  = ThreshBits'($urandom_range(lo, 1022));
      deb = MsBits'($urandom_range(0, 200));
      win = MsBits'($urandom_range(0, 3000));
      case (ph)
        0: begin hi = ThreshHighRst; lo = ThreshLowRst; deb = DebounceRst; win = WindowRst; end
        1: begin deb = 16'd0; win = 16'd0; end
        2: begin deb = 16'hFFFF; win = 16'hFFFF; end
        3: begin hi = 10'd1022; lo = 10'd1; end
        5: begin
          lo = ThreshBits'($urandom_range(300, 700));
          hi = ThreshBits'($urandom_range(1, lo - 1));
        end
        default: ;
      endcase
      program_regs(hi, lo, deb, win);
      quiet = (ph % 3 == 1);
      if (ph == 4) hold_cycles = 60;
      if (ph == 6) clock_ms = 32'hFFFF_0000;
      target = n_items + 68;
      while (n_items < target) run_pattern();
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
